/* design/gondola_pendulation_synth_unit_macros.svh */
// Assertion helpers shared by the top, phase and mix design files.
`ifndef GONDOLA_PENDULATION_SYNTH_UNIT_MACROS_SVH
`define GONDOLA_PENDULATION_SYNTH_UNIT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define GPSYN_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Condition that, once seen, must be followed by another on the next edge.
`define GPSYN_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/gpsyn_pkg.sv */
package gpsyn_pkg;

    // one beat's control travelling down the pipe
    typedef struct packed {
        logic valid;
        logic last;
    } t_beat_ctl;

    localparam int TIME_W  = 32;
    localparam int ANGLE_W = 27;
    localparam int TRIG_W  = 31;   // quarter-wave entries, 0 .. 2^30
    localparam int AMP_W   = 27;
    localparam int PROD_W  = TRIG_W + 1 + AMP_W;
    localparam int ACC_W   = 60;
    localparam int FRAC_W  = 30;
    localparam int SHIFT_W = ACC_W - FRAC_W;

    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 88;

    localparam int NUM_TONES   = 4;
    localparam int NUM_LOOKUPS = 5;
    localparam int NUM_PRODS   = 8;

    // tones, by period
    localparam int TONE_23  = 0;
    localparam int TONE_120 = 1;
    localparam int TONE_360 = 2;
    localparam int TONE_900 = 3;

    localparam int PERIOD [NUM_TONES] = '{23, 120, 360, 900};

    // table lookups
    localparam int LK_C23  = 0;
    localparam int LK_C120 = 1;
    localparam int LK_C360 = 2;
    localparam int LK_C900 = 3;
    localparam int LK_S360 = 4;

    localparam int LK_TONE [NUM_LOOKUPS] = '{TONE_23, TONE_120, TONE_360, TONE_900, TONE_360};
    localparam bit LK_IS_COS [NUM_LOOKUPS] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

    localparam logic signed [AMP_W-1:0] AMP_E1 = 27'sd312339;
    localparam logic signed [AMP_W-1:0] AMP_E2 = 27'sd937017;
    localparam logic signed [AMP_W-1:0] AMP_E3 = 27'sd2811050;
    localparam logic signed [AMP_W-1:0] AMP_E4 = 27'sd7496132;
    localparam logic signed [AMP_W-1:0] AMP_A1 = 27'sd1249355;
    localparam logic signed [AMP_W-1:0] AMP_A2 = 27'sd1874033;
    localparam logic signed [AMP_W-1:0] AMP_R1 = 27'sd13493038;
    localparam logic signed [AMP_W-1:0] AMP_R2 = 27'sd33732594;

    // products: elevation 0..3, azimuth 4..5, roll 6..7
    localparam int PROD_LK [NUM_PRODS] = '{LK_C23, LK_C120, LK_C360, LK_C900,
                                           LK_C120, LK_C360, LK_C120, LK_S360};
    localparam logic signed [AMP_W-1:0] PROD_AMP [NUM_PRODS] = '{AMP_E1, AMP_E2, AMP_E3,
        AMP_E4, AMP_A1, AMP_A2, AMP_R1, AMP_R2};

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (FRAC_W - 1));
    localparam logic signed [SHIFT_W-1:0] SAT_HI = SHIFT_W'(67108863);
    localparam logic signed [SHIFT_W-1:0] SAT_LO = -SHIFT_W'(67108864);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1 << 30;

    // Taylor denominators (2n)(2n+1)
    localparam logic [63:0] TAYLOR_D1  = 64'd6;
    localparam logic [63:0] TAYLOR_D2  = 64'd20;
    localparam logic [63:0] TAYLOR_D3  = 64'd42;
    localparam logic [63:0] TAYLOR_D4  = 64'd72;
    localparam logic [63:0] TAYLOR_D5  = 64'd110;
    localparam logic [63:0] TAYLOR_D6  = 64'd156;
    localparam logic [63:0] TAYLOR_D7  = 64'd210;
    localparam logic [63:0] TAYLOR_D8  = 64'd272;
    localparam logic [63:0] TAYLOR_D9  = 64'd342;
    localparam logic [63:0] TAYLOR_D10 = 64'd420;
    localparam logic [63:0] TAYLOR_D11 = 64'd506;
    localparam logic [63:0] TAYLOR_D12 = 64'd600;

    // Quarter-wave entry k in Q30; elaboration only. A term that has reached
    // zero stays zero, so the series needs no early exit.
    function automatic logic [TRIG_W-1:0] sine_q30(input int unsigned k,
                                                   input int unsigned addr_bits);
        logic [63:0] theta;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        theta = (HALF_PI_Q30 * 64'(k)) >> addr_bits;
        x2    = (theta * theta) >> 30;
        term  = theta;
        sum   = $signed(theta);
        term = ((term * x2) >> 30) / TAYLOR_D1;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / TAYLOR_D2;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / TAYLOR_D3;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / TAYLOR_D4;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / TAYLOR_D5;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / TAYLOR_D6;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / TAYLOR_D7;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / TAYLOR_D8;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / TAYLOR_D9;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / TAYLOR_D10; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / TAYLOR_D11; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / TAYLOR_D12; sum = sum + $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > ONE_Q30) begin
            sum = ONE_Q30;
        end
        return sum[TRIG_W-1:0];
    endfunction

    // saturate a rounded sum to the angle range
    function automatic logic signed [ANGLE_W-1:0] sat_angle(
        input logic signed [SHIFT_W-1:0] v);
        logic signed [ANGLE_W-1:0] r;
        priority if (v > SAT_HI) begin
            r = SAT_HI[ANGLE_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[ANGLE_W-1:0];
        end else begin
            r = v[ANGLE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* design/gondola_pendulation_synth_unit.sv */
// channel   | dir | beat contents
// s (in)    | in  | tdata[31:0] time_ticks, tlast last_in
// m (out)   | out | tdata[26:0] elevation, [53:27] azimuth, [80:54] roll, tlast last_out
//
// One beat per cycle while m is not stalled; each input beat passes through five register
// stages: phase multipliers, table read, weighting multipliers and two adder stages.
// After reset the quarter-wave tables are loaded, all 2^TABLE_ADDR_BITS+1 entries
// (1025 at the default), with s tready low.
// Each stage holds its beat while the stage below is full and stalled, so
// a stall on m backs up through the pipe without loss or repeat.
`include "gondola_pendulation_synth_unit_macros.svh"

module gondola_pendulation_synth_unit #(
    parameter int TABLE_ADDR_BITS = 10,
    parameter int PHASE_FRAC_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [gpsyn_pkg::TDATA_IN_W-1:0]     i_s_tdata,  // time_ticks
    input  logic                                 i_s_tlast,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // elevation_angle, azimuth_angle, roll_angle, zero pad
    output logic [gpsyn_pkg::TDATA_OUT_W-1:0]    o_m_tdata,
    output logic                                 o_m_tlast
);

    localparam int QN = 1 << TABLE_ADDR_BITS;
    localparam int AW = TABLE_ADDR_BITS + 1;
    localparam int W  = TABLE_ADDR_BITS + 2;
    localparam int TW = gpsyn_pkg::TRIG_W;
    localparam int PAD_W = gpsyn_pkg::TDATA_OUT_W - 3 * gpsyn_pkg::ANGLE_W;

    typedef logic [TW-1:0] t_rom [QN+1];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k <= QN; k++) begin
            rom[k] = gpsyn_pkg::sine_q30(k, TABLE_ADDR_BITS);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // table load after reset
    logic [AW-1:0] r_fill_addr, n_fill_addr;
    logic          r_fill_done, n_fill_done;

    always_comb begin
        n_fill_addr = r_fill_addr;
        n_fill_done = r_fill_done;
        if (!r_fill_done) begin
            if (r_fill_addr == AW'(QN)) begin
                n_fill_done = 1'b1;
            end else begin
                n_fill_addr = r_fill_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_addr <= '0;
            r_fill_done <= 1'b0;
        end else begin
            r_fill_addr <= n_fill_addr;
            r_fill_done <= n_fill_done;
        end
    end

    // phase stage
    gpsyn_pkg::t_beat_ctl in_ctl, ph_ctl, mix_ctl;
    logic [gpsyn_pkg::NUM_TONES-1:0][W-1:0] ph_phase;
    logic ph_ready;
    logic mix_ready;
    logic en2;

    assign in_ctl.valid = i_s_tvalid && r_fill_done;
    assign in_ctl.last  = i_s_tlast;
    assign o_s_tready   = ph_ready && r_fill_done;

    gpsyn_phase #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (in_ctl),
        .i_time  (i_s_tdata[gpsyn_pkg::TIME_W-1:0]),
        .o_ready (ph_ready),
        .o_ctl   (ph_ctl),
        .o_phase (ph_phase),
        .i_ready (en2)
    );

    // table read stage
    logic r_v2, r_l2;
    logic [gpsyn_pkg::NUM_LOOKUPS-1:0] n_neg, r_neg;
    logic [gpsyn_pkg::NUM_LOOKUPS-1:0][TW-1:0] trig;

    assign en2 = !r_v2 || mix_ready;

    for (genvar j = 0; j < gpsyn_pkg::NUM_LOOKUPS; j++) begin : g_lookup
        logic [W-1:0]  pos;
        logic [1:0]    quad;
        logic [AW-1:0] idx;
        logic [AW-1:0] raddr;
        // cosine is the sine a quarter turn on
        assign pos   = gpsyn_pkg::LK_IS_COS[j] ? ph_phase[gpsyn_pkg::LK_TONE[j]] + W'(QN)
                                               : ph_phase[gpsyn_pkg::LK_TONE[j]];
        assign quad  = pos[W-1 -: 2];
        assign idx   = {1'b0, pos[TABLE_ADDR_BITS-1:0]};
        assign raddr = quad[0] ? AW'(QN) - idx : idx;
        assign n_neg[j] = quad[1];

        gpsyn_ram #(
            .WIDTH (TW),
            .DEPTH (QN + 1)
        ) u_rom (
            .i_clk   (i_clk),
            .i_we    (!r_fill_done),
            .i_waddr (r_fill_addr),
            .i_wdata (SINE_ROM[r_fill_addr]),
            .i_re    (en2),
            .i_raddr (raddr),
            .o_rdata (trig[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= ph_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_neg <= n_neg;
            r_l2  <= ph_ctl.last;
        end
    end

    // weighting, sums, rounding
    gpsyn_pkg::t_beat_ctl rd_ctl;
    logic signed [gpsyn_pkg::ANGLE_W-1:0] ele, azi, rol;

    assign rd_ctl.valid = r_v2;
    assign rd_ctl.last  = r_l2;

    gpsyn_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rd_ctl),
        .i_trig  (trig),
        .i_neg   (r_neg),
        .o_ready (mix_ready),
        .o_ctl   (mix_ctl),
        .o_ele   (ele),
        .o_azi   (azi),
        .o_rol   (rol),
        .i_ready (i_m_tready)
    );

    assign o_m_tvalid = mix_ctl.valid;
    assign o_m_tlast  = mix_ctl.last;
    assign o_m_tdata  = {PAD_W'(0), rol, azi, ele};

    `GPSYN_CHECK(a_fill_bound, r_fill_addr <= AW'(QN), "table load address past end")
    `GPSYN_CHECK(a_idle_in_fill, r_fill_done || (!ph_ctl.valid && !r_v2), "beat in pipe during table load")

endmodule

/* design/gpsyn_ram.sv */
module gpsyn_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1025
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/gpsyn_phase.sv */
`include "gondola_pendulation_synth_unit_macros.svh"

module gpsyn_phase #(
    parameter int TABLE_ADDR_BITS = 10,
    parameter int PHASE_FRAC_BITS = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  gpsyn_pkg::t_beat_ctl                    i_ctl,
    input  logic [gpsyn_pkg::TIME_W-1:0]            i_time,
    output logic                                    o_ready,
    output gpsyn_pkg::t_beat_ctl                    o_ctl,
    output logic [gpsyn_pkg::NUM_TONES-1:0][TABLE_ADDR_BITS+1:0] o_phase,
    input  logic                                    i_ready
);

    localparam int W  = TABLE_ADDR_BITS + 2;
    localparam int RW = PHASE_FRAC_BITS - 8;
    localparam int PW = gpsyn_pkg::TIME_W + RW;

    logic [gpsyn_pkg::NUM_TONES-1:0][W-1:0] n_phase;
    logic [gpsyn_pkg::NUM_TONES-1:0][W-1:0] r_phase;
    logic r_valid;
    logic r_last;
    logic en;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;

    for (genvar g = 0; g < gpsyn_pkg::NUM_TONES; g++) begin : g_tone
        localparam logic [63:0] RECIP = ((64'd1 << RW) + 64'(gpsyn_pkg::PERIOD[g] / 2))
                                      / 64'(gpsyn_pkg::PERIOD[g]);
        logic [PW-1:0] prod;
        assign prod       = PW'(i_time) * PW'(RECIP[RW-1:0]);
        assign n_phase[g] = prod[PHASE_FRAC_BITS-1 -: W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_phase <= n_phase;
            r_last  <= i_ctl.last;
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.last  = r_last;
    assign o_phase     = r_phase;

    `GPSYN_NEXT(a_phase_hold, r_valid && !i_ready, r_valid && $stable(r_phase), "phase beat lost under stall")

endmodule

/* design/gpsyn_mix.sv */
`include "gondola_pendulation_synth_unit_macros.svh"

module gpsyn_mix (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  gpsyn_pkg::t_beat_ctl                               i_ctl,
    input  logic [gpsyn_pkg::NUM_LOOKUPS-1:0][gpsyn_pkg::TRIG_W-1:0] i_trig,
    input  logic [gpsyn_pkg::NUM_LOOKUPS-1:0]                  i_neg,
    output logic                                               o_ready,
    output gpsyn_pkg::t_beat_ctl                               o_ctl,
    output logic signed [gpsyn_pkg::ANGLE_W-1:0]               o_ele,
    output logic signed [gpsyn_pkg::ANGLE_W-1:0]               o_azi,
    output logic signed [gpsyn_pkg::ANGLE_W-1:0]               o_rol,
    input  logic                                               i_ready
);

    localparam int ACC_W = gpsyn_pkg::ACC_W;

    logic r_v3, r_v4, r_v5;
    logic r_l3, r_l4, r_l5;
    logic en3, en4, en5;

    logic signed [ACC_W-1:0] r_prod [gpsyn_pkg::NUM_PRODS];
    logic signed [ACC_W-1:0] r_ele_a, r_ele_b, r_azi_s, r_rol_s;
    logic signed [ACC_W-1:0] ele_sum;
    logic signed [gpsyn_pkg::ANGLE_W-1:0] r_ele, r_azi, r_rol;

    assign en5     = !r_v5 || i_ready;
    assign en4     = !r_v4 || en5;
    assign en3     = !r_v3 || en4;
    assign o_ready = en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en3) r_v3 <= i_ctl.valid;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // weighting: signed table value times amplitude
    for (genvar g = 0; g < gpsyn_pkg::NUM_PRODS; g++) begin : g_prod
        logic signed [gpsyn_pkg::TRIG_W:0] mag;
        logic signed [gpsyn_pkg::TRIG_W:0] trig_s;
        logic signed [gpsyn_pkg::PROD_W-1:0] prod;
        assign mag    = $signed({1'b0, i_trig[gpsyn_pkg::PROD_LK[g]]});
        assign trig_s = i_neg[gpsyn_pkg::PROD_LK[g]] ? -mag : mag;
        assign prod   = trig_s * gpsyn_pkg::PROD_AMP[g];
        always_ff @(posedge i_clk) begin
            if (en3) begin
                r_prod[g] <= ACC_W'(prod);
            end
        end
    end

    // rounding half is folded into the first partial sum of each angle
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_l3 <= i_ctl.last;
        end
        if (en4) begin
            r_ele_a <= r_prod[0] + r_prod[1] + gpsyn_pkg::ROUND_HALF;
            r_ele_b <= r_prod[2] + r_prod[3];
            r_azi_s <= r_prod[4] + r_prod[5] + gpsyn_pkg::ROUND_HALF;
            r_rol_s <= r_prod[6] + r_prod[7] + gpsyn_pkg::ROUND_HALF;
            r_l4    <= r_l3;
        end
        if (en5) begin
            r_ele <= gpsyn_pkg::sat_angle(ele_sum[ACC_W-1:gpsyn_pkg::FRAC_W]);
            r_azi <= gpsyn_pkg::sat_angle(r_azi_s[ACC_W-1:gpsyn_pkg::FRAC_W]);
            r_rol <= gpsyn_pkg::sat_angle(r_rol_s[ACC_W-1:gpsyn_pkg::FRAC_W]);
            r_l5  <= r_l4;
        end
    end

    assign ele_sum = r_ele_a + r_ele_b;

    assign o_ctl.valid = r_v5;
    assign o_ctl.last  = r_l5;
    assign o_ele       = r_ele;
    assign o_azi       = r_azi;
    assign o_rol       = r_rol;

    `GPSYN_NEXT(a_out_hold, r_v5 && !i_ready, r_v5 && $stable(r_ele) && $stable(r_rol), "result changed while stalled")
    `GPSYN_NEXT(a_no_overtake, r_v4 && r_v5 && !i_ready, r_v4, "stage four beat dropped behind stalled output")

endmodule

/* verif/gondola_pendulation_synth_unit_tb.sv */
`timescale 1ns / 1ps

module gondola_pendulation_synth_unit_tb;

    localparam int ADDR_BITS  = 10;
    localparam int PHASE_BITS = 32;
    localparam int WAVE_BITS  = ADDR_BITS + 2;
    localparam int QUARTER    = 1 << ADDR_BITS;
    localparam int AW         = 27;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam longint      Q30_ONE     = 64'sd1 << 30;
    localparam longint      ANGLE_HI    = 64'sd67108863;
    localparam longint      ANGLE_LO    = -64'sd67108864;

    localparam int PERIOD_23  = 23;
    localparam int PERIOD_120 = 120;
    localparam int PERIOD_360 = 360;
    localparam int PERIOD_900 = 900;

    // weights in 2^-30 rad
    localparam longint W_ELE_23  = 312339;
    localparam longint W_ELE_120 = 937017;
    localparam longint W_ELE_360 = 2811050;
    localparam longint W_ELE_900 = 7496132;
    localparam longint W_AZI_120 = 1249355;
    localparam longint W_AZI_360 = 1874033;
    localparam longint W_ROL_120 = 13493038;
    localparam longint W_ROL_360 = 33732594;

    localparam int IDLE_PCT     = 15;
    localparam int RANDOM_ITEMS = 750;
    localparam int N_DIRECTED   = 20;

    typedef struct packed {
        logic [gpsyn_pkg::TDATA_IN_W-1:0] ticks;
        logic                             last;
    } t_sample;

    typedef struct packed {
        logic signed [AW-1:0] elev;
        logic signed [AW-1:0] azim;
        logic signed [AW-1:0] roll;
        logic                 last;
    } t_angle_set;

    typedef enum int {
        SWEEP_RANDOM,
        SWEEP_RAMP,
        SWEEP_WRAP,
        SWEEP_PERIOD
    } t_sweep_kind;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_s_tvalid = 1'b0;
    logic                              o_s_tready;
    logic [gpsyn_pkg::TDATA_IN_W-1:0]  i_s_tdata = '0;   // time_ticks
    logic                              i_s_tlast = 1'b0;
    logic                              o_m_tvalid;
    logic                              i_m_tready = 1'b0;
    // elevation_angle, azimuth_angle, roll_angle, zero pad
    logic [gpsyn_pkg::TDATA_OUT_W-1:0] o_m_tdata;
    logic                              o_m_tlast;

    logic [30:0] quarter_sine_q30 [QUARTER+1];
    t_angle_set  pending_angles [$];
    int          mismatch_count = 0;
    bit          steady = 1'b0;

    // ticks of 1/256 s; phase extremes and whole, half and quarter periods of the tones
    t_sample directed_samples [N_DIRECTED] = '{
        '{32'd0,          1'b0}, '{32'd1,          1'b0}, '{32'hFFFF_FFFF, 1'b1},
        '{32'h8000_0000,  1'b0}, '{32'h7FFF_FFFF,  1'b1}, '{32'd5888,      1'b0},
        '{32'd1472,       1'b0}, '{32'd30720,      1'b1}, '{32'd7680,      1'b0},
        '{32'd15360,      1'b0}, '{32'd23040,      1'b1}, '{32'd92160,     1'b0},
        '{32'd46080,      1'b0}, '{32'd69120,      1'b1}, '{32'd230400,    1'b0},
        '{32'd115200,     1'b1}, '{32'hAAAA_AAAA,  1'b0}, '{32'h5555_5555, 1'b1},
        '{32'hFFFF_FF00,  1'b0}, '{32'h0001_0000,  1'b1}
    };

    gondola_pendulation_synth_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // truncating Taylor series for sin(pi/2 * k / QUARTER), Q30
    function automatic logic [30:0] quarter_wave_entry(input int unsigned k);
        logic [63:0] theta;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        theta = (HALF_PI_Q30 * 64'(k)) >> ADDR_BITS;
        x2    = (theta * theta) >> 30;
        term  = theta;
        sum   = longint'(theta);
        for (int n = 1; n <= 12 && term != 0; n++) begin
            term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > Q30_ONE) begin
            sum = Q30_ONE;
        end
        return sum[30:0];
    endfunction

    function automatic logic [63:0] phase_step(input int unsigned period);
        return ((64'd1 << (PHASE_BITS - 8)) + 64'(period / 2)) / 64'(period);
    endfunction

    function automatic logic [WAVE_BITS-1:0] wave_index(input logic [31:0] ticks,
                                                        input int unsigned period);
        logic [63:0] ph;
        ph = 64'(ticks) * phase_step(period);
        return ph[PHASE_BITS-1 -: WAVE_BITS];
    endfunction

    function automatic longint wave_q30(input logic [WAVE_BITS-1:0] w);
        logic [ADDR_BITS-1:0] i;
        longint               v;
        i = w[ADDR_BITS-1:0];
        v = w[ADDR_BITS] ? longint'(quarter_sine_q30[QUARTER - int'(i)])
                         : longint'(quarter_sine_q30[i]);
        return w[ADDR_BITS+1] ? -v : v;
    endfunction

    // cos is the wave a quarter cycle on
    function automatic longint tone_cos(input logic [31:0] ticks, input int unsigned period);
        logic [WAVE_BITS-1:0] w;
        w = wave_index(ticks, period) + WAVE_BITS'(QUARTER);
        return wave_q30(w);
    endfunction

    function automatic logic [AW-1:0] round_angle(input longint acc);
        longint v;
        v = (acc + (64'sd1 <<< 29)) >>> 30;
        if (v > ANGLE_HI) begin
            v = ANGLE_HI;
        end
        if (v < ANGLE_LO) begin
            v = ANGLE_LO;
        end
        return v[AW-1:0];
    endfunction

    function automatic t_angle_set pendulation_angles(input logic [31:0] ticks,
                                                      input logic last);
        t_angle_set r;
        longint     c120;
        longint     c360;
        c120   = tone_cos(ticks, PERIOD_120);
        c360   = tone_cos(ticks, PERIOD_360);
        r.elev = round_angle(W_ELE_23 * tone_cos(ticks, PERIOD_23) + W_ELE_120 * c120
                           + W_ELE_360 * c360 + W_ELE_900 * tone_cos(ticks, PERIOD_900));
        r.azim = round_angle(W_AZI_120 * c120 + W_AZI_360 * c360);
        r.roll = round_angle(W_ROL_120 * c120
                           + W_ROL_360 * wave_q30(wave_index(ticks, PERIOD_360)));
        r.last = last;
        return r;
    endfunction

    task automatic send_sample(input logic [31:0] ticks, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ticks;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        pending_angles.push_back(pendulation_angles(ticks, last));
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_angle_set want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_angles.size() == 0) begin
                $error("output beat with no sample outstanding");
                mismatch_count++;
            end else begin
                want = pending_angles.pop_front();
                check_field("elevation_angle", want.elev, $signed(o_m_tdata[AW-1:0]));
                check_field("azimuth_angle", want.azim, $signed(o_m_tdata[2*AW-1:AW]));
                check_field("roll_angle", want.roll, $signed(o_m_tdata[3*AW-1:2*AW]));
                check_field("last_out", want.last, o_m_tlast);
                check_field("tdata pad", 0, o_m_tdata[gpsyn_pkg::TDATA_OUT_W-1:3*AW]);
            end
        end
    end

    initial begin
        #(12 * 200000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int          sent;
        int          run_len;
        t_sweep_kind kind;
        logic [31:0] ticks;
        logic [31:0] stride;
        bit          noisy_last;
        for (int k = 0; k <= QUARTER; k++) begin
            quarter_sine_q30[k] = quarter_wave_entry(k);
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_samples[n]) begin
            send_sample(directed_samples[n].ticks, directed_samples[n].last);
        end

        // batches of samples, tlast on the final beat; a few with scrambled tlast
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind       = t_sweep_kind'($urandom_range(3));
            run_len    = $urandom_range(1, 40);
            noisy_last = ($urandom_range(9) == 0);
            stride     = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 8192);
            case (kind)
                SWEEP_RANDOM: begin
                    ticks  = $urandom;
                    stride = $urandom;
                end
                SWEEP_RAMP:   ticks = $urandom_range(0, 1) ? $urandom_range(0, 500000) : $urandom;
                SWEEP_WRAP:   ticks = 32'hFFFF_FFFF - $urandom_range(0, 2000);
                default: begin
                    // land on or next to whole and quarter periods
                    ticks  = $urandom_range(0, 40) * 64 * PERIOD_360 + $urandom_range(0, 3);
                    stride = 64 * PERIOD_120;
                end
            endcase
            for (int j = 0; j < run_len; j++) begin
                steady = (sent >= 250 && sent < 400);
                send_sample(ticks, noisy_last ? 1'($urandom) : (j == run_len - 1));
                ticks = ticks + stride;
                sent++;
            end
        end
        steady = 1'b0;
        i_s_tvalid <= 1'b0;

        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_angles.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/gpsyn_pkg.sv
design/gpsyn_ram.sv
design/gpsyn_phase.sv
design/gpsyn_mix.sv
design/gondola_pendulation_synth_unit.sv
verif/gondola_pendulation_synth_unit_tb.sv
